// ----- hw/rtl/jidct_pkg.sv -----
package jidct_pkg;

    localparam int CONST_FRAC_BITS = 12;
    localparam int COLUMN_SHIFT    = 10;
    localparam int ROW_SHIFT       = 17;
    localparam int BLK_DEPTH       = 64;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 32;

    // Round a constant (units of 1e-9) to CONST_FRAC_BITS fraction bits, half up
    function automatic logic [31:0] cfix(longint nano, bit neg);
        longint m;
        m = ((nano << CONST_FRAC_BITS) + 64'sd500000000) / 64'sd1000000000;
        return neg ? 32'(-m) : 32'(m);
    endfunction

    // Rotation constants, named by sign and leading digits of their value
    localparam logic [31:0] K_P0541 = cfix(64'd541196100, 1'b0);
    localparam logic [31:0] K_M1847 = cfix(64'd1847759065, 1'b1);
    localparam logic [31:0] K_P0765 = cfix(64'd765366865, 1'b0);
    localparam logic [31:0] K_P1175 = cfix(64'd1175875602, 1'b0);
    localparam logic [31:0] K_P0298 = cfix(64'd298631336, 1'b0);
    localparam logic [31:0] K_P2053 = cfix(64'd2053119869, 1'b0);
    localparam logic [31:0] K_P3072 = cfix(64'd3072711026, 1'b0);
    localparam logic [31:0] K_P1501 = cfix(64'd1501321110, 1'b0);
    localparam logic [31:0] K_M0899 = cfix(64'd899976223, 1'b1);
    localparam logic [31:0] K_M2562 = cfix(64'd2562915447, 1'b1);
    localparam logic [31:0] K_M1961 = cfix(64'd1961570560, 1'b1);
    localparam logic [31:0] K_M0390 = cfix(64'd390180644, 1'b1);

    localparam logic [31:0] COL_BIAS = 32'd1 << (COLUMN_SHIFT - 1);
    localparam logic [31:0] ROW_BIAS = (32'd1 << (ROW_SHIFT - 1)) + (32'd128 << ROW_SHIFT);

    localparam logic [3:0] LAST_MUL  = 4'd11;
    localparam logic [2:0] LAST_IDX  = 3'd7;
    localparam logic [3:0] LAST_PASS = 4'd15;
    localparam logic [3:0] READ_END  = 4'd8;

    typedef enum logic [1:0] {S_LOAD, S_READ, S_GO, S_WAIT} t_top_st;
    typedef enum logic [2:0] {PS_IDLE, PS_MUL, PS_SUM1, PS_SUM2, PS_OUT} t_pass_st;

    typedef struct packed {
        logic       load;
        logic [2:0] idx;
        logic       go;
        logic       row_mode;
    } t_pass_ctl;

    typedef struct packed {
        logic       vld;
        logic [2:0] idx;
    } t_pass_sts;

endpackage

// ----- hw/rtl/jidct_ram.sv -----
module jidct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/jidct_pass.sv -----
module jidct_pass (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jidct_pkg::t_pass_ctl i_ctl,
    input  logic [31:0]        i_data,
    output jidct_pkg::t_pass_sts o_sts,
    output logic [31:0]        o_data
);
    import jidct_pkg::*;

    t_pass_st    r_state, n_state;
    logic [3:0]  r_step;
    logic        r_row;
    logic [31:0] r_s  [8];
    logic [31:0] r_pr [12];
    logic [31:0] r_t0e, r_t1e, r_t2e, r_t3e, r_q1, r_q2;
    logic [31:0] r_x  [4];
    logic [31:0] r_tt [4];
    logic [31:0] mul_a, mul_c, mul_p, bias, out_sum;
    logic        step_end;

    // Operand select for the shared multiplier
    always_comb begin
        unique case (r_step)
            4'd0:    begin mul_a = r_s[2] + r_s[6]; mul_c = K_P0541; end
            4'd1:    begin mul_a = r_s[6]; mul_c = K_M1847; end
            4'd2:    begin mul_a = r_s[2]; mul_c = K_P0765; end
            4'd3:    begin
                mul_a = (r_s[7] + r_s[3]) + (r_s[5] + r_s[1]);
                mul_c = K_P1175;
            end
            4'd4:    begin mul_a = r_s[7]; mul_c = K_P0298; end
            4'd5:    begin mul_a = r_s[5]; mul_c = K_P2053; end
            4'd6:    begin mul_a = r_s[3]; mul_c = K_P3072; end
            4'd7:    begin mul_a = r_s[1]; mul_c = K_P1501; end
            4'd8:    begin mul_a = r_s[7] + r_s[1]; mul_c = K_M0899; end
            4'd9:    begin mul_a = r_s[5] + r_s[3]; mul_c = K_M2562; end
            4'd10:   begin mul_a = r_s[7] + r_s[3]; mul_c = K_M1961; end
            4'd11:   begin mul_a = r_s[5] + r_s[1]; mul_c = K_M0390; end
            default: begin mul_a = '0; mul_c = '0; end
        endcase
        mul_p = mul_a * mul_c;
    end

    assign bias     = r_row ? ROW_BIAS : COL_BIAS;
    assign step_end = (r_state == PS_MUL) ? (r_step == LAST_MUL)
                                          : (r_step[2:0] == LAST_IDX);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            PS_IDLE: if (i_ctl.go) n_state = PS_MUL;
            PS_MUL:  if (step_end) n_state = PS_SUM1;
            PS_SUM1: n_state = PS_SUM2;
            PS_SUM2: n_state = PS_OUT;
            PS_OUT:  if (step_end) n_state = PS_IDLE;
            default: n_state = PS_IDLE;
        endcase
    end

    // Butterfly output for the current index
    always_comb begin
        unique case (r_step[2:0])
            3'd0:    out_sum = r_x[0] + r_tt[3];
            3'd1:    out_sum = r_x[1] + r_tt[2];
            3'd2:    out_sum = r_x[2] + r_tt[1];
            3'd3:    out_sum = r_x[3] + r_tt[0];
            3'd4:    out_sum = r_x[3] - r_tt[0];
            3'd5:    out_sum = r_x[2] - r_tt[1];
            3'd6:    out_sum = r_x[1] - r_tt[2];
            default: out_sum = r_x[0] - r_tt[3];
        endcase
    end

    // Outputs
    always_comb begin
        o_sts.vld = (r_state == PS_OUT);
        o_sts.idx = r_step[2:0];
        o_data    = r_row ? 32'($signed(out_sum) >>> ROW_SHIFT)
                          : 32'($signed(out_sum) >>> COLUMN_SHIFT);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == PS_MUL || r_state == PS_OUT) begin
                r_step <= step_end ? 4'd0 : r_step + 4'd1;
            end else if (r_state == PS_IDLE) begin
                r_step <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s[i_ctl.idx] <= i_data;
        end
        if (i_ctl.go) begin
            r_row <= i_ctl.row_mode;
        end
        if (r_state == PS_MUL) begin
            r_pr[r_step] <= mul_p;
        end
        if (r_state == PS_SUM1) begin
            r_t0e <= (r_s[0] + r_s[4]) << CONST_FRAC_BITS;
            r_t1e <= (r_s[0] - r_s[4]) << CONST_FRAC_BITS;
            r_t2e <= r_pr[1] + r_pr[0];
            r_t3e <= r_pr[2] + r_pr[0];
            r_q1  <= r_pr[8] + r_pr[3];
            r_q2  <= r_pr[9] + r_pr[3];
        end
        if (r_state == PS_SUM2) begin
            r_x[0]  <= r_t0e + r_t3e + bias;
            r_x[3]  <= r_t0e - r_t3e + bias;
            r_x[1]  <= r_t1e + r_t2e + bias;
            r_x[2]  <= r_t1e - r_t2e + bias;
            r_tt[3] <= r_pr[7] + r_q1 + r_pr[11];
            r_tt[2] <= r_pr[6] + r_q2 + r_pr[10];
            r_tt[1] <= r_pr[5] + r_q2 + r_pr[11];
            r_tt[0] <= r_pr[4] + r_q1 + r_pr[10];
        end
    end

    ap_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.go |-> r_state == PS_IDLE) else $error("pass started while running");
    ap_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> r_state == PS_IDLE) else $error("sample load while running");
    ap_mul_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == PS_SUM1 |=> r_state == PS_SUM2) else $error("sum stage skipped");

endmodule

// ----- hw/rtl/jpeg_idct_islow_8x8_top.sv -----
// 8x8 integer inverse DCT with dequantization.
// Input: pulse i_start with i_coefficient and i_quant_step while o_busy is low;
// one beat is taken per cycle. Coefficients arrive in natural row-major order.
// The product coefficient*quant_step is written to the dequant memory at once.
// After the 64th beat o_busy rises and one shared 1-D unit runs 8 column passes
// then 8 row passes. Each pass makes 8 registered memory reads, a go step in
// S_GO, the 12 products of the single 32x32 multiplier, the sums in PS_SUM1
// and PS_SUM2, and 8 outputs. No new block is loaded until the transform ends.
// Output: o_strobe marks one pixel beat for one cycle with o_pixel, o_row,
// o_col; o_last flags the 64th pixel. The 8 pixels of a row come out on
// consecutive cycles, in the cycle after the row pass produces them.
// The receiver cannot stall; every strobed beat must be taken.
// Reset (synchronous, active low) returns to loading at coefficient 0;
// memory contents are not cleared and need not be.
module jpeg_idct_islow_8x8_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_coefficient,
    input  logic [15:0] i_quant_step,
    output logic        o_strobe,
    output logic [7:0]  o_pixel,
    output logic [2:0]  o_row,
    output logic [2:0]  o_col,
    output logic        o_last
);
    import jidct_pkg::*;

    t_top_st             r_state, n_state;
    logic [ADDR_W-1:0]   r_load;
    logic [3:0]          r_pass;
    logic [3:0]          r_cnt;
    logic                r_strobe, r_last;
    logic [7:0]          r_pixel;
    logic [2:0]          r_row, r_col;

    logic                accept, pass_done;
    logic [DATA_W-1:0]   dq_wdata, dq_rdata, cr_rdata, pass_out;
    logic [ADDR_W-1:0]   rd_addr, cr_waddr;
    logic                cr_we;
    logic [7:0]          pixel_c;
    t_pass_ctl           ctl;
    t_pass_sts           sts;

    assign accept    = i_start && !o_busy;
    assign dq_wdata  = {{16{i_coefficient[15]}}, i_coefficient} * {16'd0, i_quant_step};
    assign pass_done = sts.vld && (sts.idx == LAST_IDX);
    assign rd_addr   = r_pass[3] ? {r_pass[2:0], r_cnt[2:0]} : {r_cnt[2:0], r_pass[2:0]};
    assign cr_we     = sts.vld && !r_pass[3];
    assign cr_waddr  = {sts.idx, r_pass[2:0]};

    jidct_ram #(.WIDTH(DATA_W), .DEPTH(BLK_DEPTH)) u_dq_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_load),
        .i_wdata (dq_wdata),
        .i_raddr (rd_addr),
        .o_rdata (dq_rdata)
    );

    jidct_ram #(.WIDTH(DATA_W), .DEPTH(BLK_DEPTH)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (cr_we),
        .i_waddr (cr_waddr),
        .i_wdata (pass_out),
        .i_raddr (rd_addr),
        .o_rdata (cr_rdata)
    );

    jidct_pass u_pass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_data  (r_pass[3] ? cr_rdata : dq_rdata),
        .o_sts   (sts),
        .o_data  (pass_out)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (accept && r_load == ADDR_W'(BLK_DEPTH - 1)) n_state = S_READ;
            S_READ:  if (r_cnt == READ_END) n_state = S_GO;
            S_GO:    n_state = S_WAIT;
            S_WAIT:  if (pass_done) n_state = (r_pass == LAST_PASS) ? S_LOAD : S_READ;
            default: n_state = S_LOAD;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_busy       = (r_state != S_LOAD);
        ctl.load     = (r_state == S_READ) && (r_cnt != 4'd0);
        ctl.idx      = 3'(r_cnt - 4'd1);
        ctl.go       = (r_state == S_GO);
        ctl.row_mode = r_pass[3];
    end

    // Clamp to a byte
    always_comb begin
        priority if (pass_out[31])              pixel_c = 8'd0;
        else if (pass_out > 32'd255)            pixel_c = 8'd255;
        else                                    pixel_c = pass_out[7:0];
    end

    // Advance counters and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_load   <= '0;
            r_pass   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= sts.vld && r_pass[3];
            if (accept) begin
                r_load <= r_load + ADDR_W'(1);
            end
            if (r_state == S_READ) begin
                r_cnt <= r_cnt + 4'd1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_WAIT && pass_done) begin
                r_pass <= r_pass + 4'd1;
            end
        end
    end

    // Hold the pixel beat
    always_ff @(posedge i_clk) begin
        r_pixel <= pixel_c;
        r_row   <= r_pass[2:0];
        r_col   <= sts.idx;
        r_last  <= (r_pass == LAST_PASS) && (sts.idx == LAST_IDX);
    end

    assign o_strobe = r_strobe;
    assign o_pixel  = r_pixel;
    assign o_row    = r_row;
    assign o_col    = r_col;
    assign o_last   = r_last && r_strobe;

    ap_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> r_load == '0) else $error("load count moved while busy");
    ap_pass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |-> r_pass == '0) else $error("pass count not cleared");
    ap_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> r_state == S_LOAD) else $error("last pixel before block end");
    ap_vld_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.vld |-> r_state == S_WAIT) else $error("pass output outside wait");

endmodule
